FILE: rtl/cpba_pkg.sv
package cpba_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_LD,
        ST_SCAN_CHK,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_FIN
    } t_state;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_OOM = 1'b1;

    localparam int WORD_BITS = 32;
    localparam int CNT_W     = 9;
    localparam logic [CNT_W-1:0] RUN_MAX = '1;

endpackage

FILE: rtl/cpba_map.sv
module cpba_map #(
    parameter int WORDS = 8,
    parameter int AW    = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_addr,
    input  logic [31:0]   i_wdata,
    output logic [31:0]   o_rdata
);

    logic [31:0]      r_mem [WORDS];
    logic [WORDS-1:0] r_vld;
    logic [31:0]      r_rdata;
    logic             r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_addr];
            r_rvld  <= r_vld[i_addr];
        end
    end

    // unwritten words read as all used
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_addr] <= 1'b1;
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '1;

endmodule

FILE: rtl/contiguous_page_bitmap_allocator.sv
// channel | valid   | ready   | payload
// input   | i_valid | o_ready | i_opcode, i_start_page, i_page_count
// output  | o_valid | i_ready | o_status, o_page_index, o_free_pages
//
// One item at a time; o_ready is high only in the idle state.
// Allocate: each map word scanned takes a read, a load and up to four 8-page steps of
// the run scanner; then each word marked takes a read and a write, then the finish state.
// Free: a read and a write per word touched. All go through the single map memory port.
// Reset is synchronous; every page reads as used and the free count is zero.
// A stalled result is held in the output register; the next item is still taken.
module contiguous_page_bitmap_allocator
    import cpba_pkg::*;
#(
    parameter int MAP_WORDS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_opcode,
    input  logic [7:0] i_start_page,
    input  logic [8:0] i_page_count,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_status,
    output logic [7:0] o_page_index,
    output logic [8:0] o_free_pages
);

    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PW        = AW + 5;
    localparam int SW        = (PW > 8) ? PW : 8;
    localparam int EW        = ((SW > 9) ? SW : 9) + 1;
    localparam int TOTAL     = MAP_WORDS * WORD_BITS;
    localparam int COUNT_CAP = (TOTAL < 511) ? TOTAL : 511;

    localparam logic [EW-1:0]    TOTAL_E = EW'(TOTAL);
    localparam logic [CNT_W-1:0] CAP_C   = CNT_W'(COUNT_CAP);
    localparam logic [AW-1:0]    LAST_W  = AW'(MAP_WORDS - 1);

    t_state           r_state, n_state;
    logic             r_op, n_op;
    logic [CNT_W-1:0] r_need, n_need;
    logic [SW-1:0]    r_start, n_start;
    logic [EW-1:0]    r_end, n_end;
    logic [CNT_W-1:0] r_run, n_run;
    logic             r_found, n_found;
    logic [AW-1:0]    r_widx, n_widx;
    logic [31:0]      r_word, n_word;
    logic [1:0]       r_chunk, n_chunk;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_oval, n_oval;
    logic             r_status, n_status;
    logic [7:0]       r_pidx, n_pidx;
    logic [CNT_W-1:0] r_ofree, n_ofree;

    logic             map_rd, map_wr;
    logic [31:0]      map_rdata, map_wdata;

    logic [CNT_W-1:0] v_run;
    logic [SW-1:0]    v_start;
    logic             v_found;

    logic [SW-1:0]    in_start;
    logic             free_skip;
    logic [EW-6:0]    wnext;
    logic [EW-1:0]    wbound;
    logic             mark_last;
    logic [4:0]       lo_off;
    logic [31:0]      mask;
    logic             fin_go;
    logic [CNT_W-1:0] cnt_alloc, cnt_free;
    logic [CNT_W:0]   cnt_sum;

    cpba_map #(
        .WORDS (MAP_WORDS),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (map_rd),
        .i_wr_en (map_wr),
        .i_addr  (r_widx),
        .i_wdata (map_wdata),
        .o_rdata (map_rdata)
    );

    // run scanner: eight pages per step
    always_comb begin
        logic [PW-1:0] v_p;
        v_run   = r_run;
        v_start = r_start;
        v_found = 1'b0;
        v_p     = '0;
        for (int k = 0; k < 8; k++) begin
            if (!v_found) begin
                v_p = {r_widx, r_chunk, 3'(k)};
                if (r_word[k]) begin
                    v_run = '0;
                end else begin
                    if (v_run == '0) begin
                        v_start = SW'(v_p);
                    end
                    if (v_run != RUN_MAX) begin
                        v_run = v_run + 1'b1;
                    end
                    if (r_need == '0 || v_run >= r_need) begin
                        v_found = 1'b1;
                    end
                end
            end
        end
    end

    assign in_start  = SW'(i_start_page);
    assign free_skip = (i_page_count == '0) || (EW'(i_start_page) >= TOTAL_E);
    assign wnext     = (EW - 5)'(r_widx) + 1'b1;
    assign wbound    = {wnext, 5'b0};
    assign mark_last = (r_end <= wbound) || (r_widx == LAST_W);
    assign lo_off    = (r_widx == r_start[AW+4:5]) ? r_start[4:0] : 5'd0;
    assign mask      = (32'hFFFF_FFFF << lo_off) &
                       ((r_end < wbound) ? ~(32'hFFFF_FFFF << r_end[4:0]) : 32'hFFFF_FFFF);
    assign fin_go    = !r_oval || i_ready;

    assign cnt_alloc = (r_cnt > r_need) ? r_cnt - r_need : '0;
    assign cnt_sum   = {1'b0, r_cnt} + {1'b0, r_need};
    assign cnt_free  = (cnt_sum > {1'b0, CAP_C}) ? CAP_C : cnt_sum[CNT_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_opcode == OP_ALLOC) begin
                        n_state = ST_SCAN_RD;
                    end else if (free_skip) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_MARK_RD;
                    end
                end
            end
            ST_SCAN_RD:  n_state = ST_SCAN_LD;
            ST_SCAN_LD:  n_state = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                if (v_found) begin
                    n_state = (r_need == '0) ? ST_FIN : ST_MARK_RD;
                end else if (r_chunk == 2'd3) begin
                    n_state = (r_widx == LAST_W) ? ST_FIN : ST_SCAN_RD;
                end
            end
            ST_MARK_RD:  n_state = ST_MARK_WR;
            ST_MARK_WR:  n_state = mark_last ? ST_FIN : ST_MARK_RD;
            ST_FIN: begin
                if (fin_go) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready   = (r_state == ST_IDLE);
        map_rd    = (r_state == ST_SCAN_RD) || (r_state == ST_MARK_RD);
        map_wr    = (r_state == ST_MARK_WR);
        map_wdata = (r_op == OP_ALLOC) ? (map_rdata | mask) : (map_rdata & ~mask);
    end

    always_comb begin
        n_op     = r_op;
        n_need   = r_need;
        n_start  = r_start;
        n_end    = r_end;
        n_run    = r_run;
        n_found  = r_found;
        n_widx   = r_widx;
        n_word   = r_word;
        n_chunk  = r_chunk;
        n_cnt    = r_cnt;
        n_oval   = r_oval;
        n_status = r_status;
        n_pidx   = r_pidx;
        n_ofree  = r_ofree;
        if (o_valid && i_ready) begin
            n_oval = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_op    = i_opcode;
                    n_need  = i_page_count;
                    n_start = in_start;
                    n_end   = EW'(i_start_page) + EW'(i_page_count);
                    n_run   = '0;
                    n_found = 1'b0;
                    n_widx  = (i_opcode == OP_FREE && !free_skip) ? in_start[AW+4:5] : '0;
                end
            end
            ST_SCAN_LD: begin
                n_word  = map_rdata;
                n_chunk = 2'd0;
            end
            ST_SCAN_CHK: begin
                n_run   = v_run;
                n_start = v_start;
                if (v_found) begin
                    n_found = 1'b1;
                    n_end   = EW'(v_start) + EW'(r_need);
                    n_widx  = v_start[AW+4:5];
                end else begin
                    n_word  = r_word >> 8;
                    n_chunk = r_chunk + 1'b1;
                    if (r_chunk == 2'd3 && r_widx != LAST_W) begin
                        n_widx = r_widx + 1'b1;
                    end
                end
            end
            ST_MARK_WR: begin
                if (!mark_last) begin
                    n_widx = r_widx + 1'b1;
                end
            end
            ST_FIN: begin
                if (fin_go) begin
                    n_oval = 1'b1;
                    if (r_op == OP_FREE) begin
                        n_status = STAT_OK;
                        n_pidx   = 8'd0;
                        n_cnt    = cnt_free;
                    end else if (r_found) begin
                        n_status = STAT_OK;
                        n_pidx   = r_start[7:0];
                        n_cnt    = cnt_alloc;
                    end else begin
                        n_status = STAT_OOM;
                        n_pidx   = 8'd0;
                        n_cnt    = r_cnt;
                    end
                    n_ofree = n_cnt;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_oval  <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_need   <= n_need;
        r_start  <= n_start;
        r_end    <= n_end;
        r_run    <= n_run;
        r_found  <= n_found;
        r_widx   <= n_widx;
        r_word   <= n_word;
        r_chunk  <= n_chunk;
        r_status <= n_status;
        r_pidx   <= n_pidx;
        r_ofree  <= n_ofree;
    end

    assign o_valid      = r_oval;
    assign o_status     = r_status;
    assign o_page_index = r_pidx;
    assign o_free_pages = r_ofree;

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP_C)
        else $error("free count above page total");

    a_oom_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STAT_OOM) |-> (o_page_index == 8'd0))
        else $error("out-of-memory item carries a page index");

    a_mark_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MARK_WR) |-> (r_found || r_op == OP_FREE))
        else $error("map written on allocate without a run found");

    a_alloc_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_opcode == OP_ALLOC) |=> (r_state == ST_SCAN_RD))
        else $error("allocate item did not start a scan");

endmodule

FILE: sim/contiguous_page_bitmap_allocator_tb.sv
`timescale 1ns / 100ps

module contiguous_page_bitmap_allocator_tb;
    import cpba_pkg::*;

    localparam int MAP_WORDS   = 8;
    localparam int MAP_PAGES   = MAP_WORDS * WORD_BITS;
    localparam int COUNT_CAP   = (MAP_PAGES < 511) ? MAP_PAGES : 511;
    localparam int N_ITEMS     = 1750;
    localparam int N_TAIL      = 250;
    localparam int STUCK_LIMIT = 3000;
    localparam int SQUEEZE_AT  = 400;
    localparam int SQUEEZE_LEN = 300;

    typedef struct packed {
        logic             status;
        logic [7:0]       page;
        logic [CNT_W-1:0] free_pages;
    } t_alloc_reply;

    typedef struct {
        int first;
        int count;
    } t_page_run;

    class alloc_checker;
        logic [MAP_PAGES-1:0] used_map;
        logic [CNT_W-1:0]     free_cnt;
        t_alloc_reply         outcome_q[$];
        t_page_run            live_runs[$];
        int                   mismatches;

        function new();
            used_map   = '1;
            free_cnt   = '0;
            mismatches = 0;
        endfunction

        function void mark_pages(int first, int count, logic used);
            for (int p = first; p < first + count && p < MAP_PAGES; p++) begin
                used_map[p] = used;
            end
        endfunction

        function t_alloc_reply predict_outcome(logic op, logic [7:0] start,
                                               logic [8:0] cnt);
            t_alloc_reply r;
            t_page_run    pr;
            int           run;
            int           idx;
            int           sum;
            bit           found;
            r.status = STAT_OK;
            r.page   = '0;
            run      = 0;
            idx      = 0;
            found    = 1'b0;
            if (op == OP_ALLOC) begin
                for (int p = 0; p < MAP_PAGES && !found; p++) begin
                    if (used_map[p]) begin
                        run = 0;
                    end else begin
                        run++;
                        if (cnt == 0) begin
                            idx   = p;
                            found = 1'b1;
                        end else if (run >= int'(cnt)) begin
                            idx   = p + 1 - run;
                            found = 1'b1;
                        end
                    end
                end
                if (found) begin
                    mark_pages(idx, int'(cnt), 1'b1);
                    free_cnt = (free_cnt > cnt) ? free_cnt - cnt : '0;
                    r.page   = 8'(idx);
                    if (cnt != 0) begin
                        pr.first = idx;
                        pr.count = int'(cnt);
                        live_runs.push_back(pr);
                    end
                end else begin
                    r.status = STAT_OOM;
                end
            end else begin
                mark_pages(int'(start), int'(cnt), 1'b0);
                sum      = int'(free_cnt) + int'(cnt);
                free_cnt = CNT_W'((sum > COUNT_CAP) ? COUNT_CAP : sum);
            end
            r.free_pages = free_cnt;
            return r;
        endfunction

        function void note_request(logic op, logic [7:0] start, logic [8:0] cnt);
            outcome_q.push_back(predict_outcome(op, start, cnt));
        endfunction

        function void check_result(logic st, logic [7:0] pg, logic [8:0] fp);
            t_alloc_reply want;
            if (outcome_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected result status=%0b page=%0d free=%0d",
                             $time, st, pg, fp);
                end
                return;
            end
            want = outcome_q.pop_front();
            if (st !== want.status || pg !== want.page || fp !== want.free_pages) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: exp st=%0b pg=%0d fr=%0d got st=%0b pg=%0d fr=%0d",
                             $time, want.status, want.page, want.free_pages,
                             st, pg, fp);
                end
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic       i_opcode;
    logic [7:0] i_start_page;
    logic [8:0] i_page_count;
    logic       o_valid;
    logic       i_ready;
    logic       o_status;
    logic [7:0] o_page_index;
    logic [8:0] o_free_pages;

    alloc_checker chk = new();
    bit           idle_on;
    int           sent_count;
    int           stuck_cycles;

    contiguous_page_bitmap_allocator #(
        .MAP_WORDS(MAP_WORDS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_start_page (i_start_page),
        .i_page_count (i_page_count),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_page_index (o_page_index),
        .o_free_pages (o_free_pages)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_item(input logic op, input logic [7:0] start,
                             input logic [8:0] cnt);
        i_valid      <= 1'b1;
        i_opcode     <= op;
        i_start_page <= start;
        i_page_count <= cnt;
        do @(posedge i_clk); while (!o_ready);
        chk.note_request(op, start, cnt);
        sent_count++;
    endtask

    task automatic pause_sender();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    initial begin
        int        sel;
        int        k;
        logic      op;
        logic [7:0] start;
        logic [8:0] cnt;
        t_page_run r;
        idle_on      = 1'b1;
        sent_count   = 0;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_opcode     <= OP_ALLOC;
        i_start_page <= '0;
        i_page_count <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(OP_ALLOC, 8'd0,   9'd1);
        send_item(OP_ALLOC, 8'hFF,  9'd0);
        send_item(OP_FREE,  8'd0,   9'd0);
        send_item(OP_FREE,  8'd255, 9'd256);
        pause_sender();
        send_item(OP_ALLOC, 8'd0,   9'd0);
        send_item(OP_ALLOC, 8'd0,   9'd1);
        send_item(OP_ALLOC, 8'd0,   9'd0);
        send_item(OP_FREE,  8'd0,   9'd256);
        send_item(OP_ALLOC, 8'd0,   9'd256);
        pause_sender();
        send_item(OP_ALLOC, 8'd0,   9'd1);
        send_item(OP_FREE,  8'd0,   9'd256);
        send_item(OP_FREE,  8'd128, 9'd64);
        send_item(OP_ALLOC, 8'd0,   9'd32);
        send_item(OP_ALLOC, 8'd0,   9'd33);
        pause_sender();
        send_item(OP_ALLOC, 8'd0,   9'd0);
        send_item(OP_ALLOC, 8'd0,   9'd192);
        send_item(OP_ALLOC, 8'd0,   9'd191);
        send_item(OP_FREE,  8'd31,  9'd2);
        send_item(OP_ALLOC, 8'd0,   9'd3);
        send_item(OP_ALLOC, 8'd0,   9'd2);
        send_item(OP_FREE,  8'd128, 9'd128);
        send_item(OP_ALLOC, 8'd0,   9'd129);
        send_item(OP_ALLOC, 8'd0,   9'd128);
        send_item(OP_FREE,  8'h55,  9'h0AA);

        while (sent_count < N_ITEMS) begin
            idle_on = (sent_count < N_ITEMS - N_TAIL) && ((sent_count / 150) % 3 != 2);
            pause_sender();
            sel   = $urandom_range(0, 99);
            start = 8'($urandom_range(0, 255));
            op    = OP_FREE;
            if (sel < 35 && chk.live_runs.size() > 0) begin
                k     = $urandom_range(0, chk.live_runs.size() - 1);
                r     = chk.live_runs[k];
                chk.live_runs.delete(k);
                start = 8'(r.first);
                cnt   = 9'(r.count);
            end else if (sel < 70) begin
                op = OP_ALLOC;
                k  = $urandom_range(0, 99);
                if (k < 8) begin
                    cnt = '0;
                end else if (k < 70) begin
                    cnt = 9'($urandom_range(1, 8));
                end else if (k < 92) begin
                    cnt = 9'($urandom_range(9, 64));
                end else begin
                    cnt = 9'($urandom_range(65, 256));
                end
            end else if (sel < 82) begin
                cnt = 9'($urandom_range(0, 16));
            end else if (sel < 90) begin
                cnt = 9'($urandom_range(0, 256));
            end else if (sel < 98) begin
                op  = OP_ALLOC;
                cnt = 9'($urandom_range(0, 256));
            end else begin
                start = '0;
                cnt   = 9'(MAP_PAGES);
            end
            send_item(op, start, cnt);
        end
        i_valid <= 1'b0;

        k = 0;
        while (chk.outcome_q.size() != 0 && k < 5000) begin
            @(posedge i_clk);
            k++;
        end
        repeat (100) @(posedge i_clk);
        if (chk.mismatches == 0 && chk.outcome_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        int hold;
        bit squeeze_done;
        hold         = 0;
        squeeze_done = 1'b0;
        i_ready      <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                hold = 0;
                i_ready <= 1'b0;
            end else begin
                if (o_valid && i_ready) begin
                    chk.check_result(o_status, o_page_index, o_free_pages);
                end
                if (hold > 0) begin
                    hold--;
                end else if (!squeeze_done && sent_count >= SQUEEZE_AT) begin
                    hold         = SQUEEZE_LEN;
                    squeeze_done = 1'b1;
                end else if (idle_on && $urandom_range(0, 5) == 0) begin
                    hold = $urandom_range(1, 16);
                end
                i_ready <= (hold == 0);
            end
        end
    end

    initial begin
        stuck_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule
